// File: sv/amd_pkg.sv
// Package for the ARM load/store address decoder.
// Shared widths, default slot count and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package amd_pkg;

  localparam int WORD_W         = 32;
  localparam int SLOT_IDX_W     = 5;
  localparam int BYTES_W        = 8;
  localparam int SLOT_COUNT_DEF = 18;

  // Decode sequencer: accept and issue RAM read, resolve operands, form address
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OPER,
    ST_ADDR
  } amd_state_t;

endpackage

`default_nettype wire

// File: sv/amd_if.sv
// Channel interfaces for the ARM load/store address decoder.
// Depends on amd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface amd_in_if;
  import amd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic [WORD_W-1:0]     slot_value;
  logic [WORD_W-1:0]     instruction_word;
  logic                  user_mode;
  logic                  carry_flag;

  modport source (output valid, output req_type, output slot_index, output slot_value,
                  output instruction_word, output user_mode, output carry_flag,
                  input ready);
  modport sink   (input valid, input req_type, input slot_index, input slot_value,
                  input instruction_word, input user_mode, input carry_flag,
                  output ready);
endinterface

interface amd_out_if;
  import amd_pkg::*;
  logic               valid;
  logic               ready;
  logic               status;
  logic [WORD_W-1:0]  access_address;
  logic [BYTES_W-1:0] access_bytes;

  modport source (output valid, output status, output access_address, output access_bytes,
                  input ready);
  modport sink   (input valid, input status, input access_address, input access_bytes,
                  output ready);
endinterface

`default_nettype wire

// File: sv/amd_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module amd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 18
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output      logic [WIDTH-1:0]         rd_data_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output      logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

// File: sv/arm_mem_access_decoder_top.sv
// Top level of the ARM load/store effective-address decoder.
// Depends on amd_pkg, amd_if (amd_in_if, amd_out_if) and amd_ram.
//
//  channel  | dir | beat contents
//  ---------+-----+---------------------------------------------------------
//  in_bus   | in  | req_type, slot_index, slot_value, instruction_word,
//           |     | user_mode, carry_flag
//  out_bus  | out | status, access_address, access_bytes (decode beats only)
//
// A write beat is done at accept, when the slot is written into the register RAM.
// A decode beat runs the RAM read of Rn/Rm, operand fixup, then the shift and
// address add; the registered RAM read and the two-port register RAM set these steps.
// Synchronous active-low reset clears the sequencer and output valid; the RAM is
// not cleared. A stalled result waits in the output register while the next beat
// is accepted; a decode only stalls in its last step if that register is still full.
`timescale 1ns / 1ps
`default_nettype none

module arm_mem_access_decoder_top
  import amd_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  amd_in_if.sink     in_bus,
  amd_out_if.source  out_bus
);

  localparam int AW = $clog2(SLOT_COUNT);

  // instruction classes, bits 27:25
  localparam logic [2:0] CLS_MISC   = 3'd0;
  localparam logic [2:0] CLS_LS_IMM = 3'd2;
  localparam logic [2:0] CLS_LS_REG = 3'd3;
  localparam logic [2:0] CLS_BLOCK  = 3'd4;
  localparam logic [2:0] CLS_COPROC = 3'd6;

  // class 0 sub-kinds, bits 7:4
  localparam logic [3:0] XK_SWAP   = 4'h9;
  localparam logic [3:0] XK_HALF   = 4'hb;
  localparam logic [3:0] XK_DBL_LD = 4'hd;
  localparam logic [3:0] XK_DBL_ST = 4'hf;

  localparam logic [7:0] OP_SWP   = 8'h10;
  localparam logic [7:0] OP_SWPB  = 8'h14;
  localparam logic [6:0] EX_WORD  = 7'h0c;
  localparam logic [6:0] EX_DBL   = 7'h0d;
  localparam logic [6:0] EX_BYTE  = 7'h0e;
  localparam logic [6:0] EX_HALF  = 7'h0f;

  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  localparam logic [3:0] CP_SINGLE = 4'ha;
  localparam logic [3:0] CP_DOUBLE = 4'hb;
  localparam logic [3:0] COND_NV   = 4'hf;
  localparam logic [3:0] REG_PC    = 4'd15;
  localparam logic [3:0] REG_SP    = 4'd13;

  // VFP multiple addressing, bits {24,23,21}
  localparam logic [2:0] VM_IA   = 3'b010;
  localparam logic [2:0] VM_IA_W = 3'b011;
  localparam logic [2:0] VM_DB_W = 3'b101;

  localparam logic [7:0] VFP_CNT_MAX = 8'd33;

  // register number to slot
  function automatic logic [SLOT_IDX_W-1:0] map_slot(input logic [3:0] r, input logic user);
    logic hi;
    hi = user ? (r == REG_PC) : (r >= REG_SP);
    return hi ? ({1'b0, r} + 5'd2) : {1'b0, r};
  endfunction

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

  amd_state_t state_r, state_nxt;

  logic              in_acc;
  logic              in_ready;
  logic              load_out;
  logic              out_free;

  logic [WORD_W-1:0] w_r;
  logic              user_r;
  logic              carry_r;
  logic [4:0]        popcnt_r;

  logic              ram_we;
  logic [WORD_W-1:0] ram_a, ram_b;
  logic [AW-1:0]     rd_addr_a, rd_addr_b;

  logic [WORD_W-1:0] rn_val_r, rn_pc_r, rm_val_r;
  logic [WORD_W-1:0] rn_val_nxt, rn_pc_nxt, rm_val_nxt;
  logic              extra_n, extra_m, pc_n;

  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r;
  logic [WORD_W-1:0] out_addr_r;
  logic [BYTES_W-1:0] out_bytes_r;

  assign in_acc   = in_bus.valid && in_ready;
  assign out_free = !out_valid_r || out_bus.ready;

  // register RAM: writes at accept, reads addressed from the incoming beat
  assign ram_we    = in_acc && !in_bus.req_type &&
                     ({1'b0, in_bus.slot_index} < (SLOT_IDX_W+1)'(SLOT_COUNT));
  assign rd_addr_a = AW'(map_slot(in_bus.instruction_word[19:16], in_bus.user_mode));
  assign rd_addr_b = AW'(map_slot(in_bus.instruction_word[3:0], in_bus.user_mode));

  amd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOT_COUNT)
  ) u_regs (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (AW'(in_bus.slot_index)),
    .wr_data   (in_bus.slot_value),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (ram_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (ram_b)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && in_bus.req_type) state_nxt = ST_OPER;
      ST_OPER: state_nxt = ST_ADDR;
      ST_ADDR: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_OPER: ;
      ST_ADDR: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // capture the decode beat
  always_ff @(posedge clk) begin
    if (in_acc && in_bus.req_type) begin
      w_r      <= in_bus.instruction_word;
      user_r   <= in_bus.user_mode;
      carry_r  <= in_bus.carry_flag;
      popcnt_r <= {1'b0, popcount8(in_bus.instruction_word[7:0])} +
                  {1'b0, popcount8(in_bus.instruction_word[15:8])};
    end
  end

  // operand fixup: +8 for the banked slot outside user mode, PC bias on Rn
  assign extra_n    = !user_r && (w_r[19:16] == REG_SP);
  assign extra_m    = !user_r && (w_r[3:0] == REG_SP);
  assign pc_n       = (w_r[19:16] == REG_PC);
  assign rn_val_nxt = ram_a + (extra_n ? 32'd8 : 32'd0);
  assign rn_pc_nxt  = ram_a + ((extra_n || pc_n) ? 32'd8 : 32'd0);
  assign rm_val_nxt = ram_b + (extra_m ? 32'd8 : 32'd0);

  always_ff @(posedge clk) begin
    if (state_r == ST_OPER) begin
      rn_val_r <= rn_val_nxt;
      rn_pc_r  <= rn_pc_nxt;
      rm_val_r <= rm_val_nxt;
    end
  end

  // shifted register offset
  logic [4:0]        sh;
  logic [63:0]       rot;
  logic [WORD_W-1:0] shifted;

  assign sh  = w_r[11:7];
  assign rot = {rm_val_r, rm_val_r} >> sh;

  always_comb begin
    unique case (w_r[6:5])
      SH_LSL: shifted = rm_val_r << sh;
      SH_LSR: shifted = (sh == 5'd0) ? 32'd0 : (rm_val_r >> sh);
      SH_ASR: shifted = (sh == 5'd0) ? {WORD_W{rm_val_r[31]}}
                                     : $unsigned($signed(rm_val_r) >>> sh);
      SH_ROR: shifted = (sh == 5'd0) ? {carry_r, rm_val_r[31:1]} : rot[31:0];
      default: shifted = rm_val_r;
    endcase
  end

  // halfword / doubleword addressing
  logic [WORD_W-1:0] m3_base, m3_off, imm8;
  assign imm8 = {24'd0, w_r[11:8], w_r[3:0]};

  always_comb begin
    unique case (w_r[22:21])
      2'd0, 2'd1: begin m3_base = rn_pc_r;                        m3_off = rm_val_r; end
      2'd2:       begin m3_base = w_r[24] ? rn_pc_r : rn_val_r;   m3_off = imm8;     end
      default:    begin m3_base = rn_val_r;                       m3_off = imm8;     end
    endcase
  end

  // block transfer count
  logic [4:0] ldm_n;
  logic [6:0] ldm_n4;
  logic       is_rfe;

  assign is_rfe = w_r[20] && !w_r[22] && (w_r[31:28] == COND_NV) && (w_r[11:8] == CP_SINGLE);
  assign ldm_n  = is_rfe ? 5'd2 : popcnt_r;
  assign ldm_n4 = {ldm_n, 2'b00};

  // VFP multiple count
  logic [7:0] vcnt;
  logic [5:0] vcnt_adj;
  logic [7:0] vcnt4;
  logic [2:0] vmode;

  assign vcnt     = w_r[7:0];
  assign vcnt_adj = ((w_r[11:8] == CP_DOUBLE) && w_r[0]) ? (vcnt[5:0] - 6'd1) : vcnt[5:0];
  assign vcnt4    = {vcnt_adj, 2'b00};
  assign vmode    = {w_r[24], w_r[23], w_r[21]};

  // classify and pick base, offset and size
  logic               bad;
  logic               sub;
  logic [WORD_W-1:0]  base, off, addr_sum;
  logic [BYTES_W-1:0] bytes;
  logic               ldm_sel, vmul_sel;

  always_comb begin
    bad      = 1'b0;
    sub      = !w_r[23];
    base     = rn_val_r;
    off      = 32'd0;
    bytes    = 8'd0;
    ldm_sel  = 1'b0;
    vmul_sel = 1'b0;
    unique case (w_r[27:25])
      CLS_MISC: begin
        unique case (w_r[7:4])
          XK_SWAP: begin
            sub = 1'b0;
            priority if (w_r[27:20] == OP_SWP)  bytes = 8'd4;
            else if (w_r[27:20] == OP_SWPB)     bytes = 8'd1;
            else if (w_r[27:21] == EX_WORD)     bytes = 8'd4;
            else if (w_r[27:21] == EX_DBL)      bytes = 8'd8;
            else if (w_r[27:21] == EX_BYTE)     bytes = 8'd1;
            else if (w_r[27:21] == EX_HALF)     bytes = 8'd2;
            else                                bad   = 1'b1;
          end
          XK_HALF: begin
            base = m3_base; off = m3_off; bytes = 8'd2;
          end
          XK_DBL_LD: begin
            base = m3_base; off = m3_off; bytes = w_r[20] ? 8'd1 : 8'd8;
          end
          XK_DBL_ST: begin
            base = m3_base; off = m3_off; bytes = w_r[20] ? 8'd2 : 8'd8;
          end
          default: bad = 1'b1;
        endcase
      end
      CLS_LS_IMM: begin
        off   = {20'd0, w_r[11:0]};
        bytes = w_r[22] ? 8'd1 : 8'd4;
      end
      CLS_LS_REG: begin
        off   = shifted;
        bytes = w_r[22] ? 8'd1 : 8'd4;
      end
      CLS_BLOCK: begin
        // user-bank forms with writeback are rejected, except a load with PC
        if (w_r[22] && w_r[21] && !(w_r[20] && w_r[15])) bad = 1'b1;
        else ldm_sel = 1'b1;
      end
      CLS_COPROC: begin
        if ((w_r[11:8] != CP_SINGLE && w_r[11:8] != CP_DOUBLE) ||
            (w_r[11:8] == CP_DOUBLE && w_r[22])) begin
          bad = 1'b1;
        end else if (w_r[24] && !w_r[21]) begin
          off   = {22'd0, w_r[7:0], 2'b00};
          bytes = (w_r[11:8] == CP_DOUBLE) ? 8'd8 : 8'd4;
        end else begin
          vmul_sel = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase

    // load/store multiple and return from exception
    if (ldm_sel) begin
      bytes = 8'(ldm_n4);
      if (ldm_n == 5'd0) bad = 1'b1;
      unique case (w_r[24:23])
        2'b01:   begin sub = 1'b0; off = 32'd0; end
        2'b11:   begin sub = 1'b0; off = 32'd4; end
        2'b00:   begin sub = 1'b1; off = 32'(ldm_n4) - 32'd4; end
        default: begin sub = 1'b1; off = 32'(ldm_n4); end
      endcase
    end

    // VFP multiple transfers
    if (vmul_sel) begin
      bytes = vcnt4;
      if (vcnt == 8'd0 || vcnt > VFP_CNT_MAX) bad = 1'b1;
      priority if (vmode == VM_IA) begin
        base = rn_pc_r; sub = 1'b0;
      end else if (vmode == VM_IA_W) begin
        sub = 1'b0;
      end else if (vmode == VM_DB_W) begin
        sub = 1'b1; off = {24'd0, vcnt4};
      end else begin
        bad = 1'b1;
      end
    end
  end

  assign addr_sum = sub ? (base - off) : (base + off);

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out)           out_valid_nxt = 1'b1;
    else if (out_bus.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= bad;
      out_addr_r   <= bad ? 32'd0 : addr_sum;
      out_bytes_r  <= bad ? 8'd0 : bytes;
    end
  end

  assign in_bus.ready           = in_ready;
  assign out_bus.valid          = out_valid_r;
  assign out_bus.status         = out_status_r;
  assign out_bus.access_address = out_addr_r;
  assign out_bus.access_bytes   = out_bytes_r;

endmodule

`default_nettype wire

// File: sv/amd_checker.sv
// Port-level checks for the ARM load/store address decoder, bound to the top level.
// Depends on amd_pkg and arm_mem_access_decoder_top.
`timescale 1ns / 1ps
`default_nettype none

module amd_checker
  import amd_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               in_req_type,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_status,
  input wire logic [WORD_W-1:0]  out_access_address,
  input wire logic [BYTES_W-1:0] out_access_bytes
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_access_address) && $stable(out_access_bytes))
    else $error("result beat changed while stalled");

  // a register write never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_req_type && !out_valid |=> !out_valid)
    else $error("result appeared after a register write");

  // decode holds off the input while it reads the register RAM
  a_decode_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_req_type |=> !in_ready)
    else $error("input accepted during decode");

  // rejected words carry a zero payload
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_access_address == '0 && out_access_bytes == '0)
    else $error("non-zero payload on a rejected word");

  // size never exceeds the largest VFP multiple
  a_bytes_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_access_bytes <= 8'd132)
    else $error("access size out of range");

endmodule

bind arm_mem_access_decoder_top amd_checker u_amd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_bus.valid),
  .in_ready           (in_bus.ready),
  .in_req_type        (in_bus.req_type),
  .out_valid          (out_bus.valid),
  .out_ready          (out_bus.ready),
  .out_status         (out_bus.status),
  .out_access_address (out_bus.access_address),
  .out_access_bytes   (out_bus.access_bytes)
);

`default_nettype wire
